// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL of the region allocator.
// Depends on nothing; each macro turns into nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ----- rtl/core/mra_pkg.sv -----
// Package of the mesh region allocator: payload types and controller/datapath links.
// Depends on nothing.
`default_nettype none
package mra_pkg;
  localparam int unsigned FUNC_ALLOC = 0;
  localparam int unsigned FUNC_RELEASE = 1;

  typedef struct packed {
    logic       func;
    logic [7:0] app_id;
    logic [8:0] task_count;
    logic [2:0] layer_count;
    logic [1:0] first_layer;
    logic [1:0] corner;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [1:0] placed_layer;
    logic [2:0] x_min;
    logic [2:0] x_max;
    logic [2:0] y_min;
    logic [2:0] y_max;
    logic [8:0] cells_freed;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch request, reset counters
    logic clr_step;   // clearing pass: write zero at sweep address
    logic rel_step;   // release: read cell (pipelined)
    logic pos_start;  // start window at current position
    logic win_step;   // advance window walker
    logic claim;      // claim mode for the window walk
    logic pos_next;   // advance scan position
    logic nofit;      // result: no fit
    logic fit;        // result: placed
    logic relres;     // result: release
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic rel_done;
    logic win_done;   // window walk finished (last element consumed)
    logic win_fit;    // count reached target
    logic pos_last;   // position is last one
    logic bad;        // zero app id, or layers out of range
    logic is_rel;
  } sts_t;
endpackage
`default_nettype wire

// ----- rtl/core/mra_datapath.sv -----
// Datapath of the mesh region allocator: owner memory, scan counters, window walker.
// Depends on mra_pkg.
`default_nettype none
module mra_datapath #(
  parameter int GX = 8,
  parameter int GY = 8,
  parameter int GZ = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mra_pkg::req_t req,
  input  wire mra_pkg::cmd_t cmd,
  output mra_pkg::sts_t      sts,
  output mra_pkg::rsp_t      rsp
);
  import mra_pkg::*;
  localparam int CELLS = GX * GY * GZ;
  localparam int AW = $clog2(CELLS);
  localparam int XW = (GX > 1) ? $clog2(GX) : 1;
  localparam int YW = (GY > 1) ? $clog2(GY) : 1;
  localparam int ZW = (GZ > 1) ? $clog2(GZ) : 1;
  localparam int CW = $clog2(CELLS + 1);
  localparam int SW = 5;

  function automatic logic dirx_of(input logic [1:0] c);
    dirx_of = (c == 2'd1) || (c == 2'd2);
  endfunction

  logic [7:0] mem [CELLS];
  logic [7:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [7:0] wr_data;
  logic wr_en;

  req_t r;
  logic [SW-1:0] side;
  logic [XW-1:0] px;
  logic [YW-1:0] py;
  logic [ZW:0]   pk;
  logic [AW:0]   sweep;
  // window walker
  logic [ZW:0]   wz;
  logic [SW-1:0] wdy, wdx;
  logic          rv;        // read in flight
  logic [AW-1:0] ra;
  logic [XW-1:0] rx;
  logic [YW-1:0] ry;
  logic          wgo;
  logic [8:0]    cnt;
  logic [CW-1:0] freed;
  logic [XW-1:0] bx0, bx1;
  logic [YW-1:0] by0, by1;
  logic          fitr, doner;

  logic dirx, diry;
  assign dirx = (r.corner == 2'd1) || (r.corner == 2'd2);
  assign diry = r.corner[1];

  // window element coordinates (signed to clip)
  logic signed [XW+SW+1:0] nx;
  logic signed [YW+SW+1:0] ny;
  logic inb, elast;
  logic [ZW:0] ztop;
  always_comb begin
    ztop = pk + (ZW+1)'(r.layer_count) - 1'b1;
    nx = dirx ? $signed({2'b0, px}) - $signed({2'b0, wdx})
              : $signed({2'b0, px}) + $signed({2'b0, wdx});
    ny = diry ? $signed({2'b0, py}) - $signed({2'b0, wdy})
              : $signed({2'b0, py}) + $signed({2'b0, wdy});
    inb = (nx >= 0) && (nx < GX) && (ny >= 0) && (ny < GY);
    elast = (wz == ztop) && (wdy == side - 1'b1) && (wdx == side - 1'b1);
  end

  // side: least s with s*s*layers >= tasks (s <= 16)
  logic [SW-1:0] side_c;
  always_comb begin
    side_c = SW'(16);
    for (int s = 16; s >= 1; s--) begin
      if (11'(s * s) * 11'(req.layer_count) >= 11'(req.task_count)) side_c = SW'(s);
    end
  end

  logic [AW-1:0] eaddr;
  assign eaddr = AW'(wz) * AW'(GX * GY) + AW'(ny[YW-1:0]) * AW'(GX) + AW'(nx[XW-1:0]);

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // release hit on the cell read back this cycle
  logic          rel_hit;
  logic [CW-1:0] freed_sum;
  assign rel_hit = rv && r.func && (r.app_id != 8'd0) && (rd_data == r.app_id);
  assign freed_sum = freed + CW'(rel_hit);

  logic cnt_inc;
  always_comb begin
    rd_addr = cmd.rel_step ? sweep[AW-1:0] : eaddr;
    wr_en = 1'b0;
    wr_addr = ra;
    wr_data = 8'd0;
    cnt_inc = rv && (rd_data == 8'd0) && !fitr;
    if (cmd.clr_step) begin
      wr_en = 1'b1; wr_addr = sweep[AW-1:0];
    end else if (rel_hit) begin
      wr_en = 1'b1;
    end else if (rv && !r.func && cmd.claim && cnt_inc && cnt < r.task_count) begin
      wr_en = 1'b1; wr_data = r.app_id;
    end
  end

  rsp_t rsp_next;
  always_comb begin
    rsp_next = '0;
    if (cmd.fit) begin
      rsp_next.found = 1'b1;
      rsp_next.placed_layer = 2'(pk);
      if (r.task_count != 9'd0) begin
        rsp_next.x_min = 3'(bx0); rsp_next.x_max = 3'(bx1);
        rsp_next.y_min = 3'(by0); rsp_next.y_max = 3'(by1);
      end
    end else if (cmd.relres) begin
      rsp_next.found = 1'b1;
      rsp_next.cells_freed = (freed_sum > CW'(511)) ? 9'd511 : 9'(freed_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0; rv <= 1'b0; wgo <= 1'b0; doner <= 1'b0; fitr <= 1'b0;
    end else begin
      rv <= cmd.rel_step || (!cmd.pos_start && wgo && cmd.win_step && inb);
      if (cmd.load) begin
        r <= req; side <= side_c; sweep <= '0; freed <= '0;
        pk <= (ZW+1)'(req.first_layer);
        px <= dirx_of(req.corner) ? XW'(GX - 1) : '0;
        py <= req.corner[1] ? YW'(GY - 1) : '0;
        doner <= 1'b0;
      end
      if (cmd.clr_step) sweep <= sweep + 1'b1;
      if (cmd.rel_step) begin
        sweep <= sweep + 1'b1; ra <= sweep[AW-1:0];
      end
      if (rel_hit) freed <= freed + 1'b1;
      if (cmd.pos_start) begin
        wz <= pk; wdy <= '0; wdx <= '0; wgo <= 1'b1; cnt <= '0; doner <= 1'b0;
        fitr <= (r.task_count == 9'd0);
      end else if (wgo && cmd.win_step) begin
        if (inb) begin
          ra <= eaddr; rx <= nx[XW-1:0]; ry <= ny[YW-1:0];
        end
        if (elast) wgo <= 1'b0;
        if (wdx == side - 1'b1) begin
          wdx <= '0;
          if (wdy == side - 1'b1) begin wdy <= '0; wz <= wz + 1'b1; end
          else wdy <= wdy + 1'b1;
        end else wdx <= wdx + 1'b1;
      end
      if (rv && !r.func && cnt_inc) begin
        cnt <= cnt + 1'b1;
        if (cmd.claim) begin
          if (cnt == 9'd0) begin bx0 <= rx; bx1 <= rx; by0 <= ry; by1 <= ry; end
          else begin
            if (rx < bx0) bx0 <= rx;
            if (rx > bx1) bx1 <= rx;
            if (ry < by0) by0 <= ry;
            if (ry > by1) by1 <= ry;
          end
        end
        if (cnt + 1'b1 >= r.task_count) fitr <= 1'b1;
      end
      if (!wgo && !rv && !cmd.pos_start && !cmd.load) doner <= 1'b1;
      if (cmd.pos_next) begin
        if ((dirx && px == '0) || (!dirx && px == XW'(GX - 1))) begin
          px <= dirx ? XW'(GX - 1) : '0;
          if ((diry && py == '0) || (!diry && py == YW'(GY - 1))) begin
            py <= diry ? YW'(GY - 1) : '0; pk <= pk + 1'b1;
          end else py <= diry ? py - 1'b1 : py + 1'b1;
        end else px <= dirx ? px - 1'b1 : px + 1'b1;
      end
      if (cmd.fit || cmd.nofit || cmd.relres) rsp <= rsp_next;
    end
  end

  always_comb begin
    sts.clr_done = (sweep == (AW+1)'(CELLS - 1));
    sts.rel_done = (sweep == (AW+1)'(CELLS - 1));
    sts.win_done = doner;
    sts.win_fit  = fitr;
    sts.pos_last = (pk == (ZW+1)'(GZ) - (ZW+1)'(r.layer_count)) &&
                   ((dirx && px == '0) || (!dirx && px == XW'(GX - 1))) &&
                   ((diry && py == '0) || (!diry && py == YW'(GY - 1)));
    sts.bad = (r.app_id == 8'd0) || (r.layer_count == 3'd0) ||
              (32'(r.layer_count) > GZ) ||
              (32'(r.first_layer) + 32'(r.layer_count) > GZ);
    sts.is_rel = r.func;
  end
endmodule
`default_nettype wire

// ----- rtl/core/mra_ctrl.sv -----
// Controller of the mesh region allocator: sequences clearing, release and scan.
// Depends on mra_pkg.
`default_nettype none
module mra_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire mra_pkg::sts_t sts,
  output mra_pkg::cmd_t      cmd,
  output logic               busy
);
  import mra_pkg::*;
  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DEC   = 9'b000000100,
    S_REL   = 9'b000001000,
    S_RWAIT = 9'b000010000,
    S_CNT   = 9'b000100000,
    S_CLAIM = 9'b001000000,
    S_RES   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;
  state_t state, state_next;
  logic ov_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    ov_next = out_valid && out_stall;
    in_stall = !(state == S_IDLE) || (out_valid && out_stall);
    unique case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (!in_stall && in_valid) begin cmd.load = 1'b1; state_next = S_DEC; end
      end
      S_DEC: begin
        if (sts.is_rel) state_next = S_REL;
        else if (sts.bad) begin cmd.nofit = 1'b1; state_next = S_OUT; end
        else begin cmd.pos_start = 1'b1; state_next = S_CNT; end
      end
      S_REL: begin
        cmd.rel_step = 1'b1;
        if (sts.rel_done) state_next = S_RWAIT;
      end
      S_RWAIT: begin
        cmd.relres = 1'b1; state_next = S_OUT;
      end
      S_CNT: begin
        cmd.win_step = 1'b1;
        if (sts.win_done) begin
          if (sts.win_fit) begin
            cmd.pos_start = 1'b1; state_next = S_CLAIM;
          end else if (sts.pos_last) begin
            cmd.nofit = 1'b1; state_next = S_OUT;
          end else begin
            cmd.pos_next = 1'b1; state_next = S_RES;
          end
        end
      end
      S_RES: begin
        cmd.pos_start = 1'b1; state_next = S_CNT;
      end
      S_CLAIM: begin
        cmd.win_step = 1'b1; cmd.claim = 1'b1;
        if (sts.win_done) begin cmd.fit = 1'b1; state_next = S_OUT; end
      end
      S_OUT: begin
        ov_next = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; out_valid <= 1'b0;
    end else begin
      state <= state_next; out_valid <= ov_next;
    end
  end

  assign busy = (state != S_IDLE);
endmodule
`default_nettype wire

// ----- rtl/core/mesh_region_allocator.sv -----
// Top level of the mesh region allocator: joins controller and datapath.
// Depends on mra_pkg, mra_ctrl, mra_datapath and assert_macros.svh.
`default_nettype none
// Keeps an 8-bit owner per core of a GRID_X by GRID_Y by GRID_Z mesh in one
// memory with one read port and one write port. After reset a clearing pass
// zeroes the memory, during which no request is taken. A release sweeps every
// cell once. An allocate walks scan positions; at each, the window walker reads
// one window element per cycle, then waits for the last read and the done flag
// before the next position restarts, and the scan ends at the last position.
// The fitting window is walked a second time to claim cells. One request is in
// work at a time; its result sits in an output register until transferred, and
// the next request waits for that.
module mesh_region_allocator #(
  parameter int GRID_X = 8,
  parameter int GRID_Y = 8,
  parameter int GRID_Z = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire mra_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output mra_pkg::rsp_t      out_data
);
  import mra_pkg::*;
  `include "assert_macros.svh"
  cmd_t cmd;
  sts_t sts;
  logic busy;

  mra_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts, .cmd, .busy
  );

  mra_datapath #(.GX(GRID_X), .GY(GRID_Y), .GZ(GRID_Z)) u_dp (
    .clk, .rst, .req(in_data), .cmd, .sts, .rsp(out_data)
  );

  // hold intake while a result waits
  `ASSERT_IMPLIES(a_no_take_while_out, clk, rst, out_valid && out_stall, in_stall)
  // a taken request leaves the block busy
  `ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && !in_stall, busy)
  // claim and release never run together
  `ASSERT_IMPLIES(a_excl, clk, rst, cmd.claim, !cmd.rel_step)
endmodule
`default_nettype wire
